/* src/edv_pkg.sv */
// edv_pkg: shared types and constants for the edid block validator
// no dependencies; imported by edv_stream and edid_block_validator_unit
package edv_pkg;

  localparam int unsigned BLOCK_BYTES  = 128;
  localparam int unsigned BLOCK_SHIFT  = 7;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned EXT_POS      = 126;
  localparam int unsigned SIZE_W       = 17;

  localparam logic [7:0] MAX_EXT_RESET = 8'd1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SIZE    = 3'd1,
    ST_BAD_HEADER  = 3'd2,
    ST_BAD_BASE    = 3'd3,
    ST_BAD_COUNT   = 3'd4,
    ST_BAD_EXT_SUM = 3'd5
  } status_e;

  // one byte handed from the input register to the checker
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
    logic       last;
  } step_t;

  // fixed header 00 ff ff ff ff ff ff 00
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h00;
      3'd7:    val = 8'h00;
      default: val = 8'hFF;
    endcase
    return val;
  endfunction

endpackage

/* src/edv_stream.sv */
// edv_stream: per-buffer check state (count, block sums, header, extension count)
// and the status judgement at the final byte; depends on edv_pkg
module edv_stream import edv_pkg::*; #(
  parameter int unsigned MAX_BUFFER_BYTES = 32768
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_t      step_i,
  input  logic [7:0] max_ext_i,
  output status_e    status_o
);

  localparam int unsigned CNT_W = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned BLK_W = CNT_W - BLOCK_SHIFT;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d, sum_add;
  logic             hdr_q, hdr_d;
  logic             base_q, base_d;
  logic [7:0]       ext_q, ext_d;
  logic             bad_q, bad_d;
  logic             take;
  logic             blk_end;
  logic [BLK_W-1:0] blk_idx;
  logic [SIZE_W-1:0] size_w, need_w;

  // next stream state after taking this byte
  always_comb begin
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    hdr_d   = hdr_q;
    base_d  = base_q;
    ext_d   = ext_q;
    bad_d   = bad_q;
    take    = cnt_q < CNT_W'(MAX_BUFFER_BYTES);
    sum_add = sum_q + step_i.data;
    blk_end = cnt_q[BLOCK_SHIFT-1:0] == BLOCK_SHIFT'(BLOCK_BYTES - 1);
    blk_idx = cnt_q[CNT_W-1:BLOCK_SHIFT];
    if (take) begin
      if (cnt_q < CNT_W'(HEADER_BYTES) && step_i.data != hdr_byte(cnt_q[2:0])) begin
        hdr_d = 1'b0;
      end
      if (cnt_q == CNT_W'(EXT_POS)) begin
        ext_d = step_i.data;
      end
      sum_d = sum_add;
      if (blk_end) begin
        if (blk_idx == '0) begin
          base_d = sum_add == 8'h00;
        end else if (SIZE_W'(blk_idx) <= SIZE_W'(ext_d) && sum_add != 8'h00) begin
          bad_d = 1'b1;
        end
        sum_d = 8'h00;
      end
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  // first failure in priority order
  always_comb begin
    size_w = SIZE_W'(cnt_d);
    need_w = (SIZE_W'(ext_d) + SIZE_W'(1)) << BLOCK_SHIFT;
    if (size_w < SIZE_W'(BLOCK_BYTES)) begin
      status_o = ST_BAD_SIZE;
    end else if (!hdr_d) begin
      status_o = ST_BAD_HEADER;
    end else if (!base_d) begin
      status_o = ST_BAD_BASE;
    end else if (ext_d > max_ext_i) begin
      status_o = ST_BAD_COUNT;
    end else if (size_w < need_w) begin
      status_o = ST_BAD_SIZE;
    end else if (bad_d) begin
      status_o = ST_BAD_EXT_SUM;
    end else begin
      status_o = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= 8'h00;
      hdr_q  <= 1'b1;
      base_q <= 1'b0;
      ext_q  <= 8'h00;
      bad_q  <= 1'b0;
    end else if (step_i.fire) begin
      if (step_i.last) begin
        // buffer done, start clean for the next one
        cnt_q  <= '0;
        sum_q  <= 8'h00;
        hdr_q  <= 1'b1;
        base_q <= 1'b0;
        ext_q  <= 8'h00;
        bad_q  <= 1'b0;
      end else begin
        cnt_q  <= cnt_d;
        sum_q  <= sum_d;
        hdr_q  <= hdr_d;
        base_q <= base_d;
        ext_q  <= ext_d;
        bad_q  <= bad_d;
      end
    end
  end

endmodule

/* src/edid_block_validator_unit.sv */
// edid_block_validator_unit: top level with input register, status register
// and the max_extensions register; depends on edv_pkg and edv_stream
//
// Takes an EDID buffer one byte per transaction and returns one status per
// buffer, on the transaction that carries last_byte. A byte can be accepted
// every clock cycle; each byte passes through the input register and the
// status of the final byte is registered into the output register as that
// byte leaves the input register, unless that byte has to wait for the
// output. The input only stalls when a final byte is waiting and the
// previous status has not yet been taken. The max_extensions register is
// always ready and is meant to be written between buffers.
module edid_block_validator_unit import edv_pkg::*; #(
  parameter int unsigned MAX_BUFFER_BYTES = 32768
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       accept;
  logic       out_valid_q;
  status_e    status_q;
  status_e    status_c;
  logic [7:0] max_ext_q;
  step_t      step;

  assign cfg_ready_o = 1'b1;

  // only a final byte needs the result slot
  assign s1_adv     = !s1_last_q || !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign step.fire = s1_valid_q && s1_adv;
  assign step.data = s1_data_q;
  assign step.last = s1_last_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (step.fire) begin
      s1_valid_d = 1'b0;
    end
  end

  edv_stream #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_stream (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .max_ext_i (max_ext_q),
    .status_o  (status_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_ext_q   <= MAX_EXT_RESET;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (step.fire && step.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_ext_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (step.fire && step.last) begin
      status_q <= status_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_q))
    else $error("input stalled without a waiting final byte");

  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.fire && step.last) |=> out_valid_q)
    else $error("final byte processed but no status presented");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step.fire && step.last))
    else $error("status appeared without a final byte");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.fire && !step.last && !out_valid_q) |=> !out_valid_q)
    else $error("non-final byte produced a status");

endmodule

/* sim/tb_edid_block_validator_unit.sv */
// tb_edid_block_validator_unit: self-checking testbench for the edid block validator
// streams edid buffers byte by byte and checks each status against a local predictor
// depends on edv_pkg and edid_block_validator_unit
module tb_edid_block_validator_unit;
  import edv_pkg::*;

  localparam int unsigned MAX_BUFFER_BYTES = 32768;
  localparam logic [63:0] EDID_MAGIC       = 64'h00FF_FFFF_FFFF_FF00;
  localparam int unsigned RANDOM_BYTES     = 250;
  localparam int unsigned RANDOM_BUFFERS   = 2;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = 8'h00;

  // predictor state for the buffer in progress
  int unsigned fill_count   = 0;
  logic [7:0]  block_sum    = 8'h00;
  bit          header_ok    = 1'b1;
  bit          base_ok      = 1'b0;
  logic [7:0]  ext_declared = 8'h00;
  bit          ext_bad      = 1'b0;
  logic [7:0]  max_ext_cfg  = MAX_EXT_RESET;

  status_e     expected_status[$];
  status_e     due_status;
  logic [7:0]  edid_buf[$];

  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int          hold_left = 0;
  int          fail_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned buffers_judged = 0;
  int unsigned status_tally[0:5] = '{default: 0};

  edid_block_validator_unit #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // fold one accepted byte into the predictor; the final byte yields a status
  function automatic void absorb_byte(input logic [7:0] b, input logic fin);
    int unsigned at;
    status_e     verdict;
    at = fill_count;
    if (at < MAX_BUFFER_BYTES) begin
      if (at < HEADER_BYTES) begin
        if (b != EDID_MAGIC[63 - 8 * at -: 8]) header_ok = 1'b0;
      end
      if (at == EXT_POS) ext_declared = b;
      block_sum = block_sum + b;
      if (at % BLOCK_BYTES == BLOCK_BYTES - 1) begin
        if (at / BLOCK_BYTES == 0) base_ok = (block_sum == 8'h00);
        else if (at / BLOCK_BYTES <= ext_declared && block_sum != 8'h00) ext_bad = 1'b1;
        block_sum = 8'h00;
      end
      fill_count = at + 1;
    end
    if (fin) begin
      if (fill_count < BLOCK_BYTES) verdict = ST_BAD_SIZE;
      else if (!header_ok) verdict = ST_BAD_HEADER;
      else if (!base_ok) verdict = ST_BAD_BASE;
      else if (ext_declared > max_ext_cfg) verdict = ST_BAD_COUNT;
      else if (fill_count < (int'(ext_declared) + 1) * BLOCK_BYTES) verdict = ST_BAD_SIZE;
      else if (ext_bad) verdict = ST_BAD_EXT_SUM;
      else verdict = ST_OK;
      expected_status.push_back(verdict);
      fill_count   = 0;
      block_sum    = 8'h00;
      header_ok    = 1'b1;
      base_ok      = 1'b0;
      ext_declared = 8'h00;
      ext_bad      = 1'b0;
    end
  endfunction

  // result check first, then register and input transactions of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_status.size() == 0) begin
          $error("status transaction with nothing expected: status got %0d", status_o);
          fail_count++;
        end else begin
          due_status = expected_status.pop_front();
          if (status_o !== due_status) begin
            $error("status mismatch: expected %0d, actual %0d", due_status, status_o);
            fail_count++;
          end
          buffers_judged++;
          if (status_o <= 3'd5) status_tally[status_o]++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) max_ext_cfg = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        absorb_byte(data_byte_i, last_byte_i);
        bytes_taken++;
      end
    end
  end

  // receiver: long hold-off when asked, otherwise random stalls while rx_gaps is set
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= rx_gaps && ($urandom_range(99) < 20);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (tx_gaps && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic stream_buffer();
    foreach (edid_buf[i]) send_byte(edid_buf[i], i == edid_buf.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max_ext(input logic [7:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // well-formed buffer: header, extension count at byte 126, every block summing to zero
  function automatic void build_edid(input int unsigned ext, input int unsigned blocks);
    logic [7:0]  b;
    logic [7:0]  sum;
    int unsigned pos;
    edid_buf.delete();
    sum = 8'h00;
    for (int unsigned i = 0; i < blocks * BLOCK_BYTES; i++) begin
      pos = i % BLOCK_BYTES;
      if (i < HEADER_BYTES) b = EDID_MAGIC[63 - 8 * i -: 8];
      else if (i == EXT_POS) b = ext[7:0];
      else if (pos == BLOCK_BYTES - 1) b = 8'h00 - sum;
      else b = 8'($urandom_range(255));
      sum = (pos == BLOCK_BYTES - 1) ? 8'h00 : sum + b;
      edid_buf.push_back(b);
    end
  endfunction

  task automatic test_short_buffers();
    edid_buf = '{8'h00};
    stream_buffer();
    edid_buf = '{8'hFF};
    stream_buffer();
    // one byte short of a base block
    build_edid(0, 1);
    void'(edid_buf.pop_back());
    stream_buffer();
    wait_idle();
  endtask

  task automatic test_each_status();
    build_edid(1, 2);
    stream_buffer();
    // header and base sum both broken: header wins
    build_edid(0, 1);
    edid_buf[0] = 8'hFF;
    stream_buffer();
    build_edid(0, 1);
    edid_buf[50] = edid_buf[50] ^ 8'h80;
    stream_buffer();
    // no idling on either side for the rest of this test
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    build_edid(1, 2);
    edid_buf[200] = edid_buf[200] ^ 8'h01;
    stream_buffer();
    // a bad block past the declared count and a partial tail are not judged
    build_edid(0, 2);
    edid_buf[200] = edid_buf[200] ^ 8'h01;
    repeat (20) edid_buf.push_back(8'($urandom_range(255)));
    stream_buffer();
    wait_idle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_max_ext_extremes();
    write_max_ext(8'd0);
    // count over the limit is reported before the missing extension
    build_edid(1, 1);
    stream_buffer();
    build_edid(0, 1);
    stream_buffer();
    write_max_ext(8'd255);
    // count at the top limit but the extension blocks never sent
    build_edid(255, 1);
    stream_buffer();
    wait_idle();
  endtask

  task automatic make_random_buffer();
    int unsigned ext;
    int unsigned blocks;
    int unsigned len;
    if ($urandom_range(99) < 12) begin
      len = $urandom_range(1, 200);
      edid_buf.delete();
      repeat (len) edid_buf.push_back(8'($urandom_range(255)));
    end else begin
      ext = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1);
      blocks = (ext > 1) ? $urandom_range(1, 2) : ext + 1;
      if ($urandom_range(9) == 0) blocks += 1;
      build_edid(ext, blocks);
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 60)) edid_buf.push_back(8'($urandom_range(255)));
      if ($urandom_range(99) < 8)
        edid_buf[$urandom_range(7)] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(99) < 8)
        edid_buf[$urandom_range(8, 127)] ^= 8'($urandom_range(1, 255));
      if (blocks > 1 && $urandom_range(99) < 10)
        edid_buf[$urandom_range(BLOCK_BYTES, edid_buf.size() - 1)] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(99) < 8) begin
        len = $urandom_range(1, edid_buf.size() - 1);
        while (edid_buf.size() > len) void'(edid_buf.pop_back());
      end
    end
  endtask

  task automatic test_random_buffers();
    int unsigned sent;
    int unsigned buffers;
    logic [7:0]  pick;
    sent = 0;
    buffers = 0;
    while (sent < RANDOM_BYTES || buffers < RANDOM_BUFFERS) begin
      if (buffers % 2 == 0) begin
        case ($urandom_range(5))
          0:       pick = 8'd0;
          1:       pick = 8'd255;
          2:       pick = 8'd1;
          default: pick = 8'($urandom_range(2));
        endcase
        write_max_ext(pick);
      end
      make_random_buffer();
      sent += edid_buf.size();
      stream_buffer();
      buffers++;
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_left = 400;
    // one-byte buffers each produce a status, so the block backs up quickly
    repeat (30) begin
      edid_buf = '{8'($urandom_range(255))};
      stream_buffer();
    end
    build_edid(0, 1);
    stream_buffer();
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_short_buffers();
    test_each_status();
    test_max_ext_extremes();
    test_random_buffers();
    test_backpressure();
    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("run covered %0d bytes in %0d judged buffers, with the limit at 0, 255 and between",
             bytes_taken, buffers_judged);
    $display("statuses seen: ok %0d, size %0d, header %0d, base %0d, count %0d, extension %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("tb_edid_block_validator_unit: PASS");
    end else begin
      $display("tb_edid_block_validator_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #(64'd8_000_000);
    $display("tb_edid_block_validator_unit: FAIL");
    $finish;
  end

endmodule
